/* rtl/dxt_block_decoder_macros.svh */
// ----------------------------------------------------------------------------
// dxt_block_decoder_macros.svh
// Assertion macros used by the block decoder back end
// ----------------------------------------------------------------------------
`ifndef DXT_BLOCK_DECODER_MACROS_SVH
`define DXT_BLOCK_DECODER_MACROS_SVH

// same-cycle implication, off during reset
`define DXTBD_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dxt block decoder: same-cycle check failed");

// next-cycle implication, off during reset
`define DXTBD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dxt block decoder: next-cycle check failed");

`endif

/* rtl/dxtbd_pkg.sv */
// ----------------------------------------------------------------------------
// dxtbd_pkg
// Shared types and constants of the dxt block decoder
// ----------------------------------------------------------------------------
package dxtbd_pkg;

    // image width and height limit in blocks
    localparam int MAX_IMAGE_BLOCKS = 1024;
    localparam int BLK_CNT_W = ($clog2(MAX_IMAGE_BLOCKS) > 0) ? $clog2(MAX_IMAGE_BLOCKS) : 1;

    // register port
    localparam int SIZE_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int EFF_W      = ((SIZE_W > BLK_CNT_W) ? SIZE_W : BLK_CNT_W) + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORMAT_MODE  = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } cfg_reg_t;

    // stream payload widths
    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 56;
    localparam int COORD_W   = 12;

    // per-block pixel sequencing
    localparam int PIX_PER_BLK = 16;
    localparam int PIX_CNT_W   = 4;

    // block queue depth, a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // one decoded block, palettes built, waiting for pixel output
    typedef struct packed {
        rgb_t [3:0]            color_pal;
        logic [7:0][7:0]       alpha_pal;
        logic [31:0]           color_idx;
        logic [47:0]           alpha_idx;
        logic [BLK_CNT_W-1:0]  blk_col;
        logic [BLK_CNT_W-1:0]  blk_row;
        logic                  last_image;
    } blk_entry_t;

endpackage

/* rtl/dxtbd_front.sv */
// ----------------------------------------------------------------------------
// dxtbd_front
// Accepts compressed blocks, tracks block position and builds the palettes
// ----------------------------------------------------------------------------
module dxtbd_front
    import dxtbd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    output logic                   ent_valid,
    input  logic                   ent_ready,
    output blk_entry_t             ent_data
);

    // configuration
    logic              format_mode_reg;
    logic [SIZE_W-1:0] width_blocks_reg;
    logic [SIZE_W-1:0] height_blocks_reg;

    // block position
    logic [BLK_CNT_W-1:0] blk_col_reg, blk_col_next;
    logic [BLK_CNT_W-1:0] blk_row_reg, blk_row_next;
    logic [EFF_W-1:0]     eff_w, eff_h;
    logic                 col_wrap, row_wrap;

    // captured block
    logic                 stg_valid_reg, stg_valid_next;
    logic                 stg_mode_reg;
    logic [15:0]          stg_w0_reg, stg_w1_reg;
    logic [31:0]          stg_cidx_reg;
    logic [7:0]           stg_a0_reg, stg_a1_reg;
    logic [47:0]          stg_aidx_reg;
    logic [BLK_CNT_W-1:0] stg_col_reg, stg_row_reg;
    logic                 stg_last_reg;

    logic s_accept;

    function automatic logic [EFF_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [EFF_W-1:0] ve;
        ve = EFF_W'(v);
        if (v == '0) begin
            return EFF_W'(1);
        end else if (ve > EFF_W'(MAX_IMAGE_BLOCKS)) begin
            return EFF_W'(MAX_IMAGE_BLOCKS);
        end
        return ve;
    endfunction

    function automatic rgb_t expand565(input logic [15:0] w);
        rgb_t c;
        c.r = {w[4:0], 3'b000};
        c.g = {w[10:5], 2'b00};
        c.b = {w[15:11], 3'b000};
        return c;
    endfunction

    // divide by 3 through reciprocal 683/2048, exact below 1024
    function automatic logic [7:0] div3(input logic [8:0] v);
        logic [19:0] p;
        p = 20'(v) * 20'd683;
        return p[18:11];
    endfunction

    // divide by 7 through reciprocal 2341/16384, exact up to 7*255
    function automatic logic [7:0] div7(input logic [10:0] v);
        logic [22:0] p;
        p = 23'(v) * 23'd2341;
        return p[21:14];
    endfunction

    // divide by 5 through reciprocal 3277/16384, exact up to 5*255
    function automatic logic [7:0] div5(input logic [10:0] v);
        logic [22:0] p;
        p = 23'(v) * 23'd3277;
        return p[21:14];
    endfunction

    function automatic logic [7:0] third_mix(input logic [7:0] a, input logic [7:0] b);
        return div3({a, 1'b0}) + div3({1'b0, b});
    endfunction

    function automatic logic [7:0] half_mix(input logic [7:0] a, input logic [7:0] b);
        return {1'b0, a[7:1]} + {1'b0, b[7:1]};
    endfunction

    function automatic logic [10:0] wsum(input logic [2:0] wa, input logic [7:0] a,
                                         input logic [2:0] wb, input logic [7:0] b);
        return (11'(wa) * 11'(a)) + (11'(wb) * 11'(b));
    endfunction

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_mode_reg   <= 1'b0;
            width_blocks_reg  <= SIZE_W'(1);
            height_blocks_reg <= SIZE_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FORMAT_MODE:  format_mode_reg   <= cfg_wdata[0];
                CFG_IMAGE_WIDTH:  width_blocks_reg  <= cfg_wdata[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT: height_blocks_reg <= cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // block position wrap
    assign eff_w    = eff_size(width_blocks_reg);
    assign eff_h    = eff_size(height_blocks_reg);
    assign col_wrap = (EFF_W'(blk_col_reg) + EFF_W'(1)) >= eff_w;
    assign row_wrap = (EFF_W'(blk_row_reg) + EFF_W'(1)) >= eff_h;

    assign s_tready = !stg_valid_reg || ent_ready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        blk_col_next = blk_col_reg;
        blk_row_next = blk_row_reg;
        if (s_accept) begin
            if (col_wrap) begin
                blk_col_next = '0;
                blk_row_next = row_wrap ? '0 : blk_row_reg + 1'b1;
            end else begin
                blk_col_next = blk_col_reg + 1'b1;
            end
        end
    end

    always_comb begin
        stg_valid_next = stg_valid_reg;
        if (s_accept) begin
            stg_valid_next = 1'b1;
        end else if (ent_ready) begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_col_reg   <= '0;
            blk_row_reg   <= '0;
            stg_valid_reg <= 1'b0;
        end else begin
            blk_col_reg   <= blk_col_next;
            blk_row_reg   <= blk_row_next;
            stg_valid_reg <= stg_valid_next;
        end
    end

    // capture stage payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            stg_mode_reg <= format_mode_reg;
            stg_w0_reg   <= s_tdata[15:0];
            stg_w1_reg   <= s_tdata[31:16];
            stg_cidx_reg <= s_tdata[63:32];
            stg_a0_reg   <= s_tdata[71:64];
            stg_a1_reg   <= s_tdata[79:72];
            stg_aidx_reg <= s_tdata[127:80];
            stg_col_reg  <= blk_col_reg;
            stg_row_reg  <= blk_row_reg;
            stg_last_reg <= col_wrap && row_wrap;
        end
    end

    // palette build
    always_comb begin
        rgb_t c0, c1;
        c0 = expand565(stg_w0_reg);
        c1 = expand565(stg_w1_reg);

        ent_data.color_pal[0] = c0;
        ent_data.color_pal[1] = c1;
        if (stg_w0_reg > stg_w1_reg) begin
            ent_data.color_pal[2].r = third_mix(c0.r, c1.r);
            ent_data.color_pal[2].g = third_mix(c0.g, c1.g);
            ent_data.color_pal[2].b = third_mix(c0.b, c1.b);
            ent_data.color_pal[3].r = third_mix(c1.r, c0.r);
            ent_data.color_pal[3].g = third_mix(c1.g, c0.g);
            ent_data.color_pal[3].b = third_mix(c1.b, c0.b);
        end else begin
            ent_data.color_pal[2].r = half_mix(c0.r, c1.r);
            ent_data.color_pal[2].g = half_mix(c0.g, c1.g);
            ent_data.color_pal[2].b = half_mix(c0.b, c1.b);
            ent_data.color_pal[3]   = '0;
        end

        // alpha levels, fixed opaque in color-only mode
        ent_data.alpha_pal[0] = stg_a0_reg;
        ent_data.alpha_pal[1] = stg_a1_reg;
        if (stg_a0_reg > stg_a1_reg) begin
            for (int k = 2; k < 8; k++) begin
                ent_data.alpha_pal[k] = div7(wsum(3'(8 - k), stg_a0_reg,
                                                  3'(k - 1), stg_a1_reg));
            end
        end else begin
            for (int k = 2; k < 6; k++) begin
                ent_data.alpha_pal[k] = div5(wsum(3'(6 - k), stg_a0_reg,
                                                  3'(k - 1), stg_a1_reg));
            end
            ent_data.alpha_pal[6] = 8'd0;
            ent_data.alpha_pal[7] = 8'd255;
        end
        if (!stg_mode_reg) begin
            ent_data.alpha_pal = {8{8'd255}};
        end

        ent_data.color_idx  = stg_cidx_reg;
        ent_data.alpha_idx  = stg_aidx_reg;
        ent_data.blk_col    = stg_col_reg;
        ent_data.blk_row    = stg_row_reg;
        ent_data.last_image = stg_last_reg;
    end

    assign ent_valid = stg_valid_reg;

endmodule

/* rtl/dxtbd_queue.sv */
// ----------------------------------------------------------------------------
// dxtbd_queue
// Short block queue between the palette front and the pixel back end
// ----------------------------------------------------------------------------
module dxtbd_queue
    import dxtbd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  blk_entry_t in_data,
    output logic       out_valid,
    input  logic       out_pop,
    output blk_entry_t out_data
);

    blk_entry_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]    count_reg, count_next;
    logic                 push, pop;

    assign in_ready  = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = slot_reg[rd_ptr_reg];

    assign push = in_valid && in_ready;
    assign pop  = out_pop && out_valid;

    // pointers wrap naturally at a power-of-two depth
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot write
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

/* rtl/dxtbd_back.sv */
// ----------------------------------------------------------------------------
// dxtbd_back
// Walks the sixteen pixels of the head block into the output register
// ----------------------------------------------------------------------------
`include "dxt_block_decoder_macros.svh"

module dxtbd_back
    import dxtbd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  blk_entry_t           q_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    output logic                 m_tuser
);

    localparam logic [PIX_CNT_W-1:0] LAST_PIX = PIX_CNT_W'(PIX_PER_BLK - 1);

    logic [PIX_CNT_W-1:0] pix_cnt_reg, pix_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_last_reg, out_image_reg;

    logic                 pix_load;
    logic [1:0]           cidx;
    logic [2:0]           aidx;
    rgb_t                 pix_rgb;
    logic [7:0]           pix_alpha;
    logic [COORD_W-1:0]   pix_col, pix_row;

    assign pix_load = q_valid && (!out_valid_reg || m_tready);
    assign q_pop    = pix_load && (pix_cnt_reg == LAST_PIX);

    // palette lookup for the current pixel
    assign cidx      = q_data.color_idx[{pix_cnt_reg, 1'b0} +: 2];
    assign aidx      = q_data.alpha_idx[6'(pix_cnt_reg) * 6'd3 +: 3];
    assign pix_rgb   = q_data.color_pal[cidx];
    assign pix_alpha = q_data.alpha_pal[aidx];
    assign pix_col   = COORD_W'({q_data.blk_col, pix_cnt_reg[1:0]});
    assign pix_row   = COORD_W'({q_data.blk_row, pix_cnt_reg[3:2]});

    always_comb begin
        pix_cnt_next   = pix_load ? pix_cnt_reg + 1'b1 : pix_cnt_reg;
        out_valid_next = out_valid_reg;
        if (pix_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pix_cnt_reg   <= pix_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (pix_load) begin
            out_data_reg  <= {pix_row, pix_col, pix_alpha, pix_rgb.b, pix_rgb.g, pix_rgb.r};
            out_last_reg  <= pix_cnt_reg == LAST_PIX;
            out_image_reg <= (pix_cnt_reg == LAST_PIX) && q_data.last_image;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_image_reg;

    // checks
    `DXTBD_ASSERT_IMPLY(a_image_end_on_block_end, aclk, aresetn, m_tvalid && m_tuser, m_tlast)
    `DXTBD_ASSERT_IMPLY(a_mid_block_has_head, aclk, aresetn, pix_cnt_reg != '0, q_valid)
    `DXTBD_ASSERT_IMPLY(a_pop_on_last_pixel, aclk, aresetn, q_pop, pix_cnt_reg == LAST_PIX)
    `DXTBD_ASSERT_NEXT(a_load_shows_pixel, aclk, aresetn, pix_load, m_tvalid)

endmodule

/* rtl/dxt_block_decoder.sv */
// ----------------------------------------------------------------------------
// dxt_block_decoder
// BC1/BC3 style 4x4 block decoder with raster pixel output
// ----------------------------------------------------------------------------
// One compressed block is taken per input transaction and turns into sixteen
// pixel transactions in raster order, tlast on the sixteenth and tuser on the
// final pixel of the image. The pixel sequencer in the back end puts out one
// pixel per cycle while a block is queued and m_tready is high, so blocks may
// stream with no gaps. A new block is taken on the cycle after the previous
// one while the palette stage or the two-entry block queue has room, and passes
// the palette stage register and a queue slot before its first pixel enters
// the output register. The user must write registers through cfg_we, cfg_index
// and cfg_wdata only while no block is in flight; nothing enforces this.
// ----------------------------------------------------------------------------
module dxt_block_decoder
    import dxtbd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // register write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // compressed block input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // color_endpoint_first, color_endpoint_second, color_index_bits,
    // alpha_endpoint_first, alpha_endpoint_second, alpha_index_bits
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // pixel output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // red_level, green_level, blue_level, alpha_level, pixel_column, pixel_row
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,
    // last_of_image
    output logic                  m_tuser
);

    logic       ent_valid, ent_ready;
    blk_entry_t ent_data;
    logic       q_valid, q_pop;
    blk_entry_t q_data;

    // block intake and palette build
    dxtbd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .ent_valid (ent_valid),
        .ent_ready (ent_ready),
        .ent_data  (ent_data)
    );

    // decoupling queue
    dxtbd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ent_valid),
        .in_ready  (ent_ready),
        .in_data   (ent_data),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_data  (q_data)
    );

    // pixel sequencer
    dxtbd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_data   (q_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
